// ----- design/cpu_alu_register_execute_unit_assert.svh -----
// Assertion macros used by the checker of the execute unit.
`ifndef CPU_ALU_REGISTER_EXECUTE_UNIT_ASSERT_SVH
`define CPU_ALU_REGISTER_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define CPU_ALU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CPU_ALU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also holds during reset.
`define CPU_ALU_ASSERT_ALW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/cpu_alu_pkg.sv -----
// Package of the execute unit: operation codes, decoded request type and constants.
`timescale 1ns / 1ps
package cpu_alu_pkg;

  typedef enum logic [5:0] {
    OP_LDA = 6'd0, OP_LDX, OP_LDY, OP_EOR, OP_NOP_OPR, OP_AND, OP_AAC, OP_ASR,
    OP_ARR, OP_ATX, OP_AXS, OP_ANE, OP_LAE, OP_ORA, OP_ADC, OP_SBC, OP_CMP,
    OP_CPX, OP_CPY, OP_BIT, OP_LAX, OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC,
    OP_DEC, OP_SLO, OP_SRE, OP_RLA, OP_RRA, OP_ISB, OP_DCP, OP_PHP, OP_PLP,
    OP_PHA, OP_PLA, OP_DEY, OP_TAY, OP_INY, OP_INX, OP_CLC, OP_SEC, OP_CLI,
    OP_SEI, OP_TYA, OP_CLV, OP_CLD, OP_SED, OP_TXA, OP_TXS, OP_TAX, OP_TSX,
    OP_DEX, OP_NOP_IMP
  } op_t;

  // Decoded request as it sits in the queue between front and back.
  typedef struct packed {
    op_t        op;
    logic [7:0] operand;
    logic [7:0] operand_inc;
    logic [7:0] operand_dec;
    logic       to_acc;
  } uop_t;

  // Status flag bit positions.
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0] STATUS_RESET = 8'h34;
  localparam logic [7:0] ANE_MASK     = 8'hEE;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- design/cpu_alu_register_execute_unit.sv -----
// Top level of the 8-bit processor execute unit.
//
// Requests arrive on the in_ stream: an operation code, an operand byte
// and, in in_tuser, the flag that makes the accumulator the target of a
// shift or rotate. Each request gives exactly one result on the out_
// stream carrying A, X, Y, S and the status byte after the operation,
// together with the byte to write back (zero when nothing is written).
// The register file lives in the back end, so every request sees the
// registers left by the one before it.
// Throughput is one request per cycle while the receiver takes results:
// each operation is a single 8-bit add, compare or logic step in the
// back end's execute stage. An accepted request is first registered in
// the decoded-request queue, then executed, and its result is held in
// the execute stage's output register until it is taken.
// Reset clears A, X, Y and S, sets status to 0x34 and empties the queue.
// When the receiver stalls, the result waits in the output register and
// the two-entry queue still takes up to two further requests.
`timescale 1ns / 1ps
module cpu_alu_register_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op [5:0], operand [13:6], zero [15:14]
  input  logic        in_tuser,   // to_accumulator [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // acc_out, x_out, y_out, stack_out, status_out,
                                  // write_byte, 8 bits each from bit 0 up
);
  import cpu_alu_pkg::*;

  uop_t fe_uop, be_uop;
  logic fe_valid, fe_ready;
  logic be_valid, be_ready;

  cpu_alu_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .uop_valid (fe_valid),
    .uop_ready (fe_ready),
    .uop       (fe_uop)
  );

  cpu_alu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_uop   (fe_uop),
    .pop_valid  (be_valid),
    .pop_ready  (be_ready),
    .pop_uop    (be_uop)
  );

  cpu_alu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .uop_valid  (be_valid),
    .uop_ready  (be_ready),
    .uop        (be_uop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- design/cpu_alu_front.sv -----
// Front end: accepts requests, decodes the operation and precomputes operand steps.
`timescale 1ns / 1ps
module cpu_alu_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // op [5:0], operand [13:6], zero [15:14]
  input  logic               in_tuser,   // to_accumulator [0]
  output logic               uop_valid,
  input  logic               uop_ready,
  output cpu_alu_pkg::uop_t  uop
);
  import cpu_alu_pkg::*;

  logic [5:0] code;
  op_t        op;

  assign code = in_tdata[5:0];

  always_comb begin
    // Codes past the last operation behave as the implied no-operation.
    if (code > 6'(OP_NOP_IMP)) begin
      op = OP_NOP_IMP;
    end else begin
      op = op_t'(code);
    end
  end

  always_comb begin
    uop.op          = op;
    uop.operand     = in_tdata[13:6];
    uop.operand_inc = in_tdata[13:6] + 8'd1;
    uop.operand_dec = in_tdata[13:6] - 8'd1;
    uop.to_acc      = in_tuser && (op inside {OP_ASL, OP_LSR, OP_ROL, OP_ROR});
  end

  assign uop_valid = in_tvalid;
  assign in_tready = uop_ready;

endmodule

// ----- design/cpu_alu_queue.sv -----
// Short queue of decoded requests between the front and back ends.
`timescale 1ns / 1ps
module cpu_alu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cpu_alu_pkg::uop_t  push_uop,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cpu_alu_pkg::uop_t  pop_uop
);
  import cpu_alu_pkg::*;

  uop_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_uop    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_uop;
    end
  end

endmodule

// ----- design/cpu_alu_back.sv -----
// Back end: register file, combinational execution and the output register.
`timescale 1ns / 1ps
module cpu_alu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               uop_valid,
  output logic               uop_ready,
  input  cpu_alu_pkg::uop_t  uop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata
);
  import cpu_alu_pkg::*;

  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  x_r, x_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [7:0]  p_r, p_nxt;
  logic [7:0]  wb_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r;
  logic        fire;

  // Sets N and Z from a result byte.
  function automatic logic [7:0] set_zn(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r       = f;
    r[FL_N] = v[7];
    r[FL_Z] = (v == 8'd0);
    return r;
  endfunction

  // Binary add with carry: {carry, overflow, sum}.
  function automatic logic [9:0] add8(input logic [7:0] a, input logic [7:0] b,
                                      input logic cin);
    logic [8:0] s;
    logic       ov;
    s  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    ov = (a[7] ^ s[7]) & (b[7] ^ s[7]);
    return {s[8], ov, s[7:0]};
  endfunction

  // Compare: {carry (no borrow), difference}.
  function automatic logic [8:0] cmp8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] d;
    d = {1'b0, a} - {1'b0, b};
    return {~d[8], d[7:0]};
  endfunction

  logic [7:0] v, t;
  logic [9:0] sum;
  logic [8:0] dif;

  always_comb begin
    v       = uop.operand;
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    sp_nxt  = sp_r;
    p_nxt   = p_r;
    wb_nxt  = 8'd0;
    t       = 8'd0;
    sum     = 10'd0;
    dif     = 9'd0;
    unique case (uop.op)
      OP_LDA, OP_PLA: begin
        acc_nxt = v;
        p_nxt   = set_zn(p_r, v);
      end
      OP_LDX: begin
        x_nxt = v;
        p_nxt = set_zn(p_r, v);
      end
      OP_LDY: begin
        y_nxt = v;
        p_nxt = set_zn(p_r, v);
      end
      OP_EOR: begin
        acc_nxt = acc_r ^ v;
        p_nxt   = set_zn(p_r, acc_nxt);
      end
      OP_AND: begin
        acc_nxt = acc_r & v;
        p_nxt   = set_zn(p_r, acc_nxt);
      end
      OP_AAC: begin
        acc_nxt     = acc_r & v;
        p_nxt       = set_zn(p_r, acc_nxt);
        p_nxt[FL_C] = acc_nxt[7];
      end
      OP_ASR: begin
        t           = acc_r & v;
        acc_nxt     = {1'b0, t[7:1]};
        p_nxt       = set_zn(p_r, acc_nxt);
        p_nxt[FL_C] = t[0];
      end
      OP_ARR: begin
        t           = acc_r & v;
        acc_nxt     = {p_r[FL_C], t[7:1]};
        p_nxt       = set_zn(p_r, acc_nxt);
        p_nxt[FL_C] = acc_nxt[6];
        p_nxt[FL_V] = acc_nxt[6] ^ acc_nxt[5];
      end
      OP_ATX, OP_LAX: begin
        acc_nxt = v;
        x_nxt   = v;
        p_nxt   = set_zn(p_r, v);
      end
      OP_AXS: begin
        dif         = cmp8(acc_r & x_r, v);
        x_nxt       = dif[7:0];
        p_nxt       = set_zn(p_r, dif[7:0]);
        p_nxt[FL_C] = dif[8];
      end
      OP_ANE: begin
        acc_nxt = (acc_r | ANE_MASK) & x_r & v;
        p_nxt   = set_zn(p_r, acc_nxt);
      end
      OP_LAE: begin
        sp_nxt  = sp_r & v;
        x_nxt   = sp_nxt;
        acc_nxt = sp_nxt;
        p_nxt   = set_zn(p_r, sp_nxt);
      end
      OP_ORA: begin
        acc_nxt = acc_r | v;
        p_nxt   = set_zn(p_r, acc_nxt);
      end
      OP_ADC, OP_SBC, OP_RRA, OP_ISB: begin
        // Subtraction adds the inverted operand; the carry-in of RRA is
        // the bit its rotate shifts out.
        if (uop.op == OP_ADC) begin
          sum = add8(acc_r, v, p_r[FL_C]);
        end else if (uop.op == OP_SBC) begin
          sum = add8(acc_r, ~v, p_r[FL_C]);
        end else if (uop.op == OP_RRA) begin
          wb_nxt = {p_r[FL_C], v[7:1]};
          sum    = add8(acc_r, wb_nxt, v[0]);
        end else begin
          wb_nxt = uop.operand_inc;
          sum    = add8(acc_r, ~uop.operand_inc, p_r[FL_C]);
        end
        acc_nxt     = sum[7:0];
        p_nxt       = set_zn(p_r, sum[7:0]);
        p_nxt[FL_V] = sum[8];
        p_nxt[FL_C] = sum[9];
      end
      OP_CMP, OP_CPX, OP_CPY, OP_DCP: begin
        if (uop.op == OP_CMP) begin
          dif = cmp8(acc_r, v);
        end else if (uop.op == OP_CPX) begin
          dif = cmp8(x_r, v);
        end else if (uop.op == OP_CPY) begin
          dif = cmp8(y_r, v);
        end else begin
          wb_nxt = uop.operand_dec;
          dif    = cmp8(acc_r, uop.operand_dec);
        end
        p_nxt       = set_zn(p_r, dif[7:0]);
        p_nxt[FL_C] = dif[8];
      end
      OP_BIT: begin
        p_nxt       = set_zn(p_r, acc_r & v);
        p_nxt[FL_N] = v[7];
        p_nxt[FL_V] = v[6];
      end
      OP_ASL, OP_ROL: begin
        t           = uop.to_acc ? acc_r : v;
        wb_nxt      = {t[6:0], (uop.op == OP_ROL) & p_r[FL_C]};
        p_nxt       = set_zn(p_r, wb_nxt);
        p_nxt[FL_C] = t[7];
        if (uop.to_acc) begin
          acc_nxt = wb_nxt;
          wb_nxt  = 8'd0;
        end
      end
      OP_LSR, OP_ROR: begin
        t           = uop.to_acc ? acc_r : v;
        wb_nxt      = {(uop.op == OP_ROR) & p_r[FL_C], t[7:1]};
        p_nxt       = set_zn(p_r, wb_nxt);
        p_nxt[FL_C] = t[0];
        if (uop.to_acc) begin
          acc_nxt = wb_nxt;
          wb_nxt  = 8'd0;
        end
      end
      OP_INC: begin
        wb_nxt = uop.operand_inc;
        p_nxt  = set_zn(p_r, wb_nxt);
      end
      OP_DEC: begin
        wb_nxt = uop.operand_dec;
        p_nxt  = set_zn(p_r, wb_nxt);
      end
      OP_SLO: begin
        wb_nxt      = {v[6:0], 1'b0};
        acc_nxt     = acc_r | wb_nxt;
        p_nxt       = set_zn(p_r, acc_nxt);
        p_nxt[FL_C] = v[7];
      end
      OP_SRE: begin
        wb_nxt      = {1'b0, v[7:1]};
        acc_nxt     = acc_r ^ wb_nxt;
        p_nxt       = set_zn(p_r, acc_nxt);
        p_nxt[FL_C] = v[0];
      end
      OP_RLA: begin
        wb_nxt      = {v[6:0], p_r[FL_C]};
        acc_nxt     = acc_r & wb_nxt;
        p_nxt       = set_zn(p_r, acc_nxt);
        p_nxt[FL_C] = v[7];
      end
      OP_PHP: begin
        wb_nxt       = p_r;
        wb_nxt[FL_B] = 1'b1;
        wb_nxt[FL_U] = 1'b1;
      end
      OP_PLP: begin
        p_nxt       = v;
        p_nxt[FL_B] = 1'b0;
        p_nxt[FL_U] = 1'b1;
      end
      OP_PHA: wb_nxt = acc_r;
      OP_DEY: begin
        y_nxt = y_r - 8'd1;
        p_nxt = set_zn(p_r, y_nxt);
      end
      OP_INY: begin
        y_nxt = y_r + 8'd1;
        p_nxt = set_zn(p_r, y_nxt);
      end
      OP_TAY: begin
        y_nxt = acc_r;
        p_nxt = set_zn(p_r, acc_r);
      end
      OP_INX: begin
        x_nxt = x_r + 8'd1;
        p_nxt = set_zn(p_r, x_nxt);
      end
      OP_DEX: begin
        x_nxt = x_r - 8'd1;
        p_nxt = set_zn(p_r, x_nxt);
      end
      OP_TAX: begin
        x_nxt = acc_r;
        p_nxt = set_zn(p_r, acc_r);
      end
      OP_TSX: begin
        x_nxt = sp_r;
        p_nxt = set_zn(p_r, sp_r);
      end
      OP_TYA: begin
        acc_nxt = y_r;
        p_nxt   = set_zn(p_r, y_r);
      end
      OP_TXA: begin
        acc_nxt = x_r;
        p_nxt   = set_zn(p_r, x_r);
      end
      OP_TXS: sp_nxt = x_r;
      OP_CLC: p_nxt[FL_C] = 1'b0;
      OP_SEC: p_nxt[FL_C] = 1'b1;
      OP_CLI: p_nxt[FL_I] = 1'b0;
      OP_SEI: p_nxt[FL_I] = 1'b1;
      OP_CLV: p_nxt[FL_V] = 1'b0;
      OP_CLD: p_nxt[FL_D] = 1'b0;
      OP_SED: p_nxt[FL_D] = 1'b1;
      OP_NOP_OPR, OP_NOP_IMP: begin
      end
      default: begin
      end
    endcase
  end

  // A request executes whenever the output register is free or being emptied.
  assign uop_ready = !out_valid_r || out_tready;
  assign fire      = uop_valid && uop_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'd0;
      x_r         <= 8'd0;
      y_r         <= 8'd0;
      sp_r        <= 8'd0;
      p_r         <= STATUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        acc_r <= acc_nxt;
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        sp_r  <= sp_nxt;
        p_r   <= p_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {wb_nxt, p_nxt, sp_nxt, y_nxt, x_nxt, acc_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/cpu_alu_checker.sv -----
// Port-level checker for the execute unit and its bind to the top level.
`timescale 1ns / 1ps
`include "cpu_alu_register_execute_unit_assert.svh"
module cpu_alu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  logic [2:0] pending_r, pending_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Requests accepted whose results have not yet been taken.
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `CPU_ALU_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `CPU_ALU_ASSERT_ALW(a_reset_idle, rst_n && $past(!rst_n), !out_tvalid, "result shown straight after reset")
  `CPU_ALU_ASSERT_IMP(a_no_phantom, out_tvalid, pending_r != 3'd0 && pending_r <= 3'd3, "result without a pending request")
  `CPU_ALU_ASSERT_IMP(a_u_flag, out_tvalid, out_tdata[37], "status U flag cleared")

endmodule

bind cpu_alu_register_execute_unit cpu_alu_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the execute unit: a directed request table, then random requests.
module testbench;
  import cpu_alu_pkg::*;

  localparam int RANDOM_REQUESTS = 1450;
  localparam int MAX_WAIT        = 18;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 20;

  localparam logic [5:0] OP_UNUSED_FIRST = 6'(OP_NOP_IMP) + 6'd1;
  localparam logic [5:0] OP_UNUSED_LAST  = 6'h3F;

  // Register file as it leaves the unit; acc_out sits in the lowest byte.
  typedef struct packed {
    logic [7:0] write_byte;
    logic [7:0] status;
    logic [7:0] sp;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] acc;
  } regs_t;

  typedef struct {
    logic [5:0] op;
    logic [7:0] operand;
    logic       to_acc;
    logic       typed;
    regs_t      regs;
  } request_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // Model copy of the register file.
  logic [7:0] a_r;
  logic [7:0] x_r;
  logic [7:0] y_r;
  logic [7:0] s_r;
  logic [7:0] p_r;

  regs_t        expected_regs_q [$];
  request_row_t directed_rows [$];
  logic         op_seen [64];
  string        field_names [6] = '{"acc_out", "x_out", "y_out", "stack_out",
                                    "status_out", "write_byte"};

  int   mismatches      = 0;
  int   requests_sent   = 0;
  int   results_checked = 0;
  int   stall_left      = 0;
  logic send_burst      = 1'b0;
  logic recv_burst      = 1'b0;

  cpu_alu_register_execute_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void set_nz(input logic [7:0] v);
    p_r[FL_N] = v[7];
    p_r[FL_Z] = (v == 8'h00);
  endfunction

  function automatic void add_with_carry(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, a_r} + {1'b0, v} + {8'h00, p_r[FL_C]};
    p_r[FL_V] = (a_r[7] ^ sum[7]) & (v[7] ^ sum[7]);
    p_r[FL_C] = sum[8];
    a_r = sum[7:0];
    set_nz(a_r);
  endfunction

  function automatic void subtract_with_borrow(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, a_r} + {1'b0, ~v} + {8'h00, p_r[FL_C]};
    p_r[FL_V] = (a_r[7] ^ sum[7]) & (a_r[7] ^ v[7]);
    p_r[FL_C] = sum[8];
    a_r = sum[7:0];
    set_nz(a_r);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
    set_nz(r - v);
    p_r[FL_C] = (r >= v);
  endfunction

  function automatic logic [7:0] shift_left(input logic [7:0] v, input logic rotate);
    logic [7:0] r;
    r = {v[6:0], rotate & p_r[FL_C]};
    p_r[FL_C] = v[7];
    set_nz(r);
    return r;
  endfunction

  function automatic logic [7:0] shift_right(input logic [7:0] v, input logic rotate);
    logic [7:0] r;
    r = {rotate & p_r[FL_C], v[7:1]};
    p_r[FL_C] = v[0];
    set_nz(r);
    return r;
  endfunction

  // Carries out one request on the model register file and returns the registers after it.
  function automatic regs_t execute_op(input logic [5:0] op, input logic [7:0] v,
                                       input logic to_acc);
    logic [7:0] wb;
    logic [7:0] t;
    wb = 8'h00;
    case (op)
      OP_LDA, OP_PLA: begin a_r = v; set_nz(v); end
      OP_LDX:     begin x_r = v; set_nz(v); end
      OP_LDY:     begin y_r = v; set_nz(v); end
      OP_EOR:     begin a_r = a_r ^ v; set_nz(a_r); end
      OP_AND:     begin a_r = a_r & v; set_nz(a_r); end
      OP_AAC:     begin a_r = a_r & v; set_nz(a_r); p_r[FL_C] = a_r[7]; end
      OP_ASR:     a_r = shift_right(a_r & v, 1'b0);
      OP_ARR: begin
        t = v & a_r;
        a_r = {p_r[FL_C], t[7:1]};
        set_nz(a_r);
        p_r[FL_C] = a_r[6];
        p_r[FL_V] = a_r[6] ^ a_r[5];
      end
      OP_ATX, OP_LAX: begin a_r = v; x_r = v; set_nz(v); end
      OP_AXS: begin
        t = a_r & x_r;
        p_r[FL_C] = (t >= v);
        x_r = t - v;
        set_nz(x_r);
      end
      OP_ANE:     begin a_r = (a_r | ANE_MASK) & x_r & v; set_nz(a_r); end
      OP_LAE:     begin s_r = s_r & v; x_r = s_r; a_r = s_r; set_nz(s_r); end
      OP_ORA:     begin a_r = a_r | v; set_nz(a_r); end
      OP_ADC:     add_with_carry(v);
      OP_SBC:     subtract_with_borrow(v);
      OP_CMP:     compare_reg(a_r, v);
      OP_CPX:     compare_reg(x_r, v);
      OP_CPY:     compare_reg(y_r, v);
      OP_BIT:     begin set_nz(a_r & v); p_r[FL_N] = v[7]; p_r[FL_V] = v[6]; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        t = to_acc ? a_r : v;
        if (op == OP_ASL || op == OP_ROL) t = shift_left(t, op == OP_ROL);
        else t = shift_right(t, op == OP_ROR);
        if (to_acc) a_r = t;
        else wb = t;
      end
      OP_INC:     begin wb = v + 8'd1; set_nz(wb); end
      OP_DEC:     begin wb = v - 8'd1; set_nz(wb); end
      OP_SLO:     begin wb = shift_left(v, 1'b0); a_r = a_r | wb; set_nz(a_r); end
      OP_SRE:     begin wb = shift_right(v, 1'b0); a_r = a_r ^ wb; set_nz(a_r); end
      OP_RLA:     begin wb = shift_left(v, 1'b1); a_r = a_r & wb; set_nz(a_r); end
      OP_RRA:     begin wb = shift_right(v, 1'b1); add_with_carry(wb); end
      OP_ISB:     begin wb = v + 8'd1; subtract_with_borrow(wb); end
      OP_DCP:     begin wb = v - 8'd1; compare_reg(a_r, wb); end
      OP_PHP:     begin wb = p_r; wb[FL_B] = 1'b1; wb[FL_U] = 1'b1; end
      OP_PLP:     begin p_r = v; p_r[FL_B] = 1'b0; p_r[FL_U] = 1'b1; end
      OP_PHA:     wb = a_r;
      OP_DEY:     begin y_r = y_r - 8'd1; set_nz(y_r); end
      OP_TAY:     begin y_r = a_r; set_nz(y_r); end
      OP_INY:     begin y_r = y_r + 8'd1; set_nz(y_r); end
      OP_INX:     begin x_r = x_r + 8'd1; set_nz(x_r); end
      OP_CLC:     p_r[FL_C] = 1'b0;
      OP_SEC:     p_r[FL_C] = 1'b1;
      OP_CLI:     p_r[FL_I] = 1'b0;
      OP_SEI:     p_r[FL_I] = 1'b1;
      OP_TYA:     begin a_r = y_r; set_nz(a_r); end
      OP_CLV:     p_r[FL_V] = 1'b0;
      OP_CLD:     p_r[FL_D] = 1'b0;
      OP_SED:     p_r[FL_D] = 1'b1;
      OP_TXA:     begin a_r = x_r; set_nz(a_r); end
      OP_TXS:     s_r = x_r;
      OP_TAX:     begin x_r = a_r; set_nz(x_r); end
      OP_TSX:     begin x_r = s_r; set_nz(x_r); end
      OP_DEX:     begin x_r = x_r - 8'd1; set_nz(x_r); end
      default:    ;
    endcase
    return {wb, p_r, s_r, y_r, x_r, a_r};
  endfunction

  task automatic add_row(input logic [5:0] op, input logic [7:0] operand,
                         input logic to_acc, input logic typed, input regs_t regs);
    request_row_t row;
    row.op      = op;
    row.operand = operand;
    row.to_acc  = to_acc;
    row.typed   = typed;
    row.regs    = regs;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatches++;
    $display("[%0t] result %0d %s: got %h, expected %h", $time, results_checked, what,
             got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [5:0] op, input logic [7:0] operand,
                              input logic to_acc, input logic typed, input regs_t typed_regs);
    int    gap;
    regs_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {2'b00, operand, op};
    in_tuser  = to_acc;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = execute_op(op, operand, to_acc);
    expected_regs_q.push_back(typed ? typed_regs : predicted);
    op_seen[op] = 1'b1;
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic check_result(input regs_t got);
    regs_t want;
    if (expected_regs_q.size() == 0) begin
      report_mismatch("arrived with no request outstanding", got, '0);
    end else begin
      want = expected_regs_q.pop_front();
      for (int i = 0; i < 6; i++)
        if (got[8*i +: 8] !== want[8*i +: 8])
          report_mismatch(field_names[i], {40'd0, got[8*i +: 8]}, {40'd0, want[8*i +: 8]});
      results_checked++;
      if (results_checked % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result(out_tdata);
      stall_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timed out: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [5:0] op;
    logic [7:0] operand;
    int         codes_covered;

    foreach (op_seen[i]) op_seen[i] = 1'b0;

    // Expected registers are typed in as {write_byte, status, sp, y, x, acc}.
    add_row(OP_NOP_IMP,     8'h00, 1'b0, 1'b1, {8'h00, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_UNUSED_LAST, 8'hFF, 1'b1, 1'b1, {8'h00, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_LDA,         8'hFF, 1'b0, 1'b1, {8'h00, 8'hB4, 8'h00, 8'h00, 8'h00, 8'hFF});
    add_row(OP_LDA,         8'h00, 1'b0, 1'b1, {8'h00, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_SEC,         8'h00, 1'b0, 1'b1, {8'h00, 8'h37, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_PHP,         8'h00, 1'b0, 1'b1, {8'h37, 8'h37, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_PLP,         8'hFF, 1'b0, 1'b1, {8'h00, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_PHP,         8'h00, 1'b0, 1'b1, {8'hFF, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_PLP,         8'h00, 1'b0, 1'b1, {8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00});
    add_row(OP_LDX,         8'hFF, 1'b0, 1'b1, {8'h00, 8'hA0, 8'h00, 8'h00, 8'hFF, 8'h00});
    add_row(OP_TXS,         8'h00, 1'b0, 1'b1, {8'h00, 8'hA0, 8'hFF, 8'h00, 8'hFF, 8'h00});
    add_row(OP_LAE,         8'h7F, 1'b0, 1'b1, {8'h00, 8'h20, 8'h7F, 8'h00, 8'h7F, 8'h7F});
    add_row(OP_LDA,         8'h7F, 1'b0, 1'b0, '0);
    add_row(OP_ADC,         8'h01, 1'b0, 1'b0, '0);
    add_row(OP_ADC,         8'hFF, 1'b0, 1'b0, '0);
    add_row(OP_SBC,         8'h80, 1'b0, 1'b0, '0);
    add_row(OP_CMP,         8'hFF, 1'b0, 1'b0, '0);
    add_row(OP_BIT,         8'hC0, 1'b0, 1'b0, '0);
    add_row(OP_ARR,         8'hFF, 1'b0, 1'b0, '0);
    add_row(OP_ATX,         8'h5A, 1'b0, 1'b0, '0);
    add_row(OP_AXS,         8'hFF, 1'b0, 1'b0, '0);
    add_row(OP_ANE,         8'hFF, 1'b0, 1'b0, '0);
    add_row(OP_ROR,         8'h00, 1'b1, 1'b0, '0);
    add_row(OP_ROL,         8'h80, 1'b0, 1'b0, '0);
    // The accumulator select must be ignored outside the shifts and rotates.
    add_row(OP_INC,         8'hFF, 1'b1, 1'b0, '0);

    a_r = 8'h00;
    x_r = 8'h00;
    y_r = 8'h00;
    s_r = 8'h00;
    p_r = STATUS_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].operand, directed_rows[i].to_acc,
                   directed_rows[i].typed, directed_rows[i].regs);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0)
        op = 6'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else op = 6'($urandom_range(0, OP_NOP_IMP));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       operand = 8'h00;
          1:       operand = 8'h01;
          2:       operand = 8'h7F;
          3:       operand = 8'h80;
          default: operand = 8'hFF;
        endcase
      end else begin
        operand = 8'($urandom_range(0, 255));
      end
      send_request(op, operand, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
    in_tvalid = 1'b0;

    while (expected_regs_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    codes_covered = 0;
    foreach (op_seen[i]) if (op_seen[i]) codes_covered++;
    $display("Sent %0d requests covering %0d of 64 operation codes; %0d results checked.",
             requests_sent, codes_covered, results_checked);
    $display("Field mismatches seen: %0d", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
